@@ src/sra_pkg.sv @@
// Package with shared types, register codes and reset constants of the slab rebalance automover.
`default_nettype none

package sra_pkg;

  // Size of the per-class table.
  localparam int SRA_MAX_CLASSES = 256;

  // Field widths.
  localparam int SRA_TIME_W  = 32;
  localparam int SRA_CLASS_W = 8;
  localparam int SRA_EV_W    = 64;
  localparam int SRA_PAGES_W = 16;
  localparam int SRA_CNT_W   = 8;
  localparam int SRA_CFG_W   = 16;

  // Register reset values.
  localparam logic [15:0] SRA_RST_RUN_INTERVAL = 16'd10;
  localparam logic [7:0]  SRA_RST_IDLE_ROUNDS  = 8'd3;
  localparam logic [7:0]  SRA_RST_WIN_ROUNDS   = 8'd3;
  localparam logic [15:0] SRA_RST_MIN_PAGES    = 16'd2;

  // Counter ceiling for streaks and wins.
  localparam logic [SRA_CNT_W-1:0] SRA_CNT_MAX = '1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    SRA_REG_RUN_INTERVAL = 2'd0,
    SRA_REG_IDLE_ROUNDS  = 2'd1,
    SRA_REG_WIN_ROUNDS   = 2'd2,
    SRA_REG_MIN_PAGES    = 2'd3
  } sra_reg_t;

  // One entry of the per-class memory.
  typedef struct packed {
    logic [SRA_EV_W-1:0]  prev_ev;
    logic [SRA_CNT_W-1:0] streak;
  } sra_entry_t;

endpackage

`default_nettype wire

@@ src/sra_in_if.sv @@
// Input channel interface: one class record per item.
`default_nettype none

interface sra_in_if
  import sra_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [SRA_TIME_W-1:0]  now;
  logic [SRA_CLASS_W-1:0] class_index;
  logic [SRA_EV_W-1:0]    evictions;
  logic [SRA_PAGES_W-1:0] pages;
  logic                   last;

  modport source (output valid, now, class_index, evictions, pages, last, input ready);
  modport sink   (input valid, now, class_index, evictions, pages, last, output ready);
endinterface

`default_nettype wire

@@ src/sra_out_if.sv @@
// Result channel interface: one decision per round.
`default_nettype none

interface sra_out_if
  import sra_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic                   evaluated;
  logic                   decided;
  logic [SRA_CLASS_W-1:0] source_class;
  logic [SRA_CLASS_W-1:0] dest_class;

  modport source (output valid, evaluated, decided, source_class, dest_class, input ready);
  modport sink   (input valid, evaluated, decided, source_class, dest_class, output ready);
endinterface

`default_nettype wire

@@ src/slab_rebalance_automover.sv @@
// Top level of the slab rebalance automover: per-class memory, round state and result register.
//
//  Channel | Direction | Handshake     | Payload
//  in_ch   | input     | valid / ready | now, class_index, evictions, pages, last
//  out_ch  | output    | valid / ready | evaluated, decided, source_class, dest_class
//  cfg_*   | input     | cfg_we only   | cfg_index, cfg_data
//
// One item is accepted per cycle unless the input stalls. The per-class memory is read when an
// item is accepted and written back in the next cycle; a closing item loads the result register.
// Back-to-back items of the same class are served by a bypass of the write-back data.
// Input stalls only while a closing item waits for a full result register that is not drained.
// Reset restores the register defaults and clears the per-class valid bits.
`default_nettype none

module slab_rebalance_automover
  import sra_pkg::*;
#(
  parameter int MAX_CLASSES = SRA_MAX_CLASSES
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  sra_in_if.sink                    in_ch,
  sra_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [SRA_CFG_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_CLASSES);
  localparam logic [SRA_CLASS_W:0] NCLS = (SRA_CLASS_W+1)'(MAX_CLASSES);

  // Configuration registers.
  logic [15:0] run_interval_r;
  logic [7:0]  idle_rounds_r;
  logic [7:0]  win_rounds_r;
  logic [15:0] min_pages_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_interval_r <= SRA_RST_RUN_INTERVAL;
      idle_rounds_r  <= SRA_RST_IDLE_ROUNDS;
      win_rounds_r   <= SRA_RST_WIN_ROUNDS;
      min_pages_r    <= SRA_RST_MIN_PAGES;
    end else if (cfg_we) begin
      unique case (sra_reg_t'(cfg_index))
        SRA_REG_RUN_INTERVAL: run_interval_r <= cfg_data;
        SRA_REG_IDLE_ROUNDS:  idle_rounds_r  <= cfg_data[7:0];
        SRA_REG_WIN_ROUNDS:   win_rounds_r   <= cfg_data[7:0];
        SRA_REG_MIN_PAGES:    min_pages_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage one item registers.
  logic                   s1_vld_r;
  logic [SRA_TIME_W-1:0]  s1_now_r;
  logic [SRA_CLASS_W-1:0] s1_cls_r;
  logic [SRA_EV_W-1:0]    s1_ev_r;
  logic [SRA_PAGES_W-1:0] s1_pages_r;
  logic                   s1_last_r;

  logic out_vld_r;
  logic s1_adv, s1_go, in_acc;
  logic [AW-1:0] in_idx, s1_idx;

  // Stage one moves on unless a closing item meets a full, stalled result register.
  assign s1_adv   = !s1_vld_r || !s1_last_r || !out_vld_r || out_ch.ready;
  assign s1_go    = s1_vld_r && s1_adv;
  assign in_ch.ready = s1_adv;
  assign in_acc   = in_ch.valid && s1_adv;
  assign in_idx   = in_ch.class_index[AW-1:0];
  assign s1_idx   = s1_cls_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_adv) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_now_r   <= in_ch.now;
      s1_cls_r   <= in_ch.class_index;
      s1_ev_r    <= in_ch.evictions;
      s1_pages_r <= in_ch.pages;
      s1_last_r  <= in_ch.last;
    end
  end

  // Per-class memory with registered read and valid bits for the zero reset.
  sra_entry_t             mem [MAX_CLASSES];
  logic [MAX_CLASSES-1:0] ent_vld_r;
  sra_entry_t             rd_q_r;
  logic                   rd_vld_r;
  sra_entry_t             fwd_q_r;
  logic                   fwd_hit_r;
  logic                   mem_we;
  sra_entry_t             wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[s1_idx] <= wr_data;
    end
    if (in_acc) begin
      rd_q_r   <= mem[in_idx];
      rd_vld_r <= ent_vld_r[in_idx];
    end
    if (mem_we && in_acc && (in_ch.class_index == s1_cls_r)) begin
      fwd_q_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (mem_we) begin
        ent_vld_r[s1_idx] <= 1'b1;
      end
      if (in_acc) begin
        fwd_hit_r <= mem_we && (in_ch.class_index == s1_cls_r);
      end
    end
  end

  // Round state.
  logic                   in_round_r;
  logic                   round_live_r;
  logic [SRA_TIME_W-1:0]  next_run_r;
  logic [SRA_CLASS_W-1:0] src_r;
  logic [SRA_EV_W-1:0]    best_delta_r;
  logic [SRA_CLASS_W-1:0] best_class_r;
  logic [SRA_CLASS_W-1:0] winner_r;
  logic [SRA_CNT_W-1:0]   win_cnt_r;

  // Result register.
  logic                   out_eval_r;
  logic                   out_dec_r;
  logic [SRA_CLASS_W-1:0] out_src_r;
  logic [SRA_CLASS_W-1:0] out_dst_r;

  // Per-item evaluation.
  sra_entry_t             cur;
  logic                   gate_ok, live_eff, in_range, take;
  logic [SRA_EV_W-1:0]    delta;
  logic                   idle_hit;
  logic [SRA_CNT_W-1:0]   streak_new;
  logic [SRA_CLASS_W-1:0] src_eff, best_class_eff, src_nxt, best_class_nxt;
  logic [SRA_EV_W-1:0]    best_delta_eff, best_delta_nxt;
  logic                   win_same;
  logic [SRA_CNT_W-1:0]   win_inc;
  logic [SRA_CLASS_W-1:0] dest;

  always_comb begin
    if (fwd_hit_r) begin
      cur = fwd_q_r;
    end else if (rd_vld_r) begin
      cur = rd_q_r;
    end else begin
      cur = '0;
    end

    gate_ok  = (s1_now_r >= next_run_r);
    live_eff = in_round_r ? round_live_r : gate_ok;
    in_range = (s1_cls_r != '0) && ({1'b0, s1_cls_r} < NCLS);
    take     = s1_go && !s1_last_r && live_eff && in_range;

    delta      = s1_ev_r - cur.prev_ev;
    idle_hit   = (delta == '0) && (s1_pages_r > min_pages_r);
    streak_new = idle_hit ? ((cur.streak == SRA_CNT_MAX) ? cur.streak
                                                          : cur.streak + 1'b1)
                          : '0;

    src_eff        = in_round_r ? src_r : '0;
    best_delta_eff = in_round_r ? best_delta_r : '0;
    best_class_eff = in_round_r ? best_class_r : '0;

    src_nxt        = src_eff;
    best_delta_nxt = best_delta_eff;
    best_class_nxt = best_class_eff;
    if (take && idle_hit && (src_eff == '0) && (streak_new >= idle_rounds_r)) begin
      src_nxt = s1_cls_r;
    end
    if (take && !idle_hit && (delta > best_delta_eff)) begin
      best_delta_nxt = delta;
      best_class_nxt = s1_cls_r;
    end

    mem_we          = take;
    wr_data.prev_ev = s1_ev_r;
    wr_data.streak  = streak_new;

    // Winner tracking at the close of the round.
    win_same = (winner_r != '0) && (winner_r == best_class_eff);
    win_inc  = (win_cnt_r == SRA_CNT_MAX) ? win_cnt_r : win_cnt_r + 1'b1;
    dest     = (win_same && (win_inc >= win_rounds_r)) ? winner_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_round_r   <= 1'b0;
      round_live_r <= 1'b0;
      next_run_r   <= '0;
      src_r        <= '0;
      best_delta_r <= '0;
      best_class_r <= '0;
      winner_r     <= '0;
      win_cnt_r    <= '0;
    end else if (s1_go) begin
      in_round_r   <= !s1_last_r;
      round_live_r <= live_eff && !s1_last_r;
      src_r        <= src_nxt;
      best_delta_r <= best_delta_nxt;
      best_class_r <= best_class_nxt;
      if (!in_round_r && gate_ok) begin
        next_run_r <= s1_now_r + {{(SRA_TIME_W-16){1'b0}}, run_interval_r};
      end
      if (s1_last_r && live_eff) begin
        if (win_same) begin
          win_cnt_r <= win_inc;
        end else begin
          win_cnt_r <= SRA_CNT_W'(1);
          winner_r  <= best_class_eff;
        end
      end
    end
  end

  // Result register: loaded by a closing item, cleared when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_eval_r <= live_eff;
      out_dec_r  <= live_eff && (src_eff != '0) && (dest != '0);
      out_src_r  <= live_eff ? src_eff : '0;
      out_dst_r  <= live_eff ? dest : '0;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.evaluated    = out_eval_r;
  assign out_ch.decided      = out_dec_r;
  assign out_ch.source_class = out_src_r;
  assign out_ch.dest_class   = out_dst_r;

  // A new result only follows a closing item that left stage one.
  a_result_from_close: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(s1_go && s1_last_r))
    else $error("result appeared without a closing item");

  // A decision always names both classes.
  a_decided_names: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_dec_r) |-> ((out_src_r != '0) && (out_dst_r != '0)))
    else $error("decided without source and destination");

  // A skipped round reports no classes.
  a_skip_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_eval_r) |-> ((out_src_r == '0) && (out_dst_r == '0) && !out_dec_r))
    else $error("skipped round reported classes");

  // The bypass is armed only by a write-back in the accepting cycle.
  a_bypass_src: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(in_acc) && fwd_hit_r) |-> $past(mem_we))
    else $error("bypass armed without a write-back");

endmodule

`default_nettype wire

@@ test/sra_decision_monitor.sv @@
// Monitor that predicts each round decision of the automover and compares it with the result channel.
module sra_decision_monitor
  import sra_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  sra_in_if                         in_ch,
  sra_out_if                        out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [SRA_CFG_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        decisions_due
);

  typedef struct packed {
    logic                   evaluated;
    logic                   decided;
    logic [SRA_CLASS_W-1:0] source_class;
    logic [SRA_CLASS_W-1:0] dest_class;
  } decision_t;

  // Register copies.
  logic [15:0] run_interval;
  logic [7:0]  idle_rounds;
  logic [7:0]  win_rounds;
  logic [15:0] min_pages;

  // Per-class history and round state.
  logic [SRA_EV_W-1:0]    prev_ev  [SRA_MAX_CLASSES];
  logic [SRA_CNT_W-1:0]   idle_run [SRA_MAX_CLASSES];
  logic [SRA_CLASS_W-1:0] leader_class;
  logic [SRA_CNT_W-1:0]   lead_count;
  logic [SRA_TIME_W-1:0]  next_eval_time;
  logic                   round_counts;
  logic                   round_open;
  logic [SRA_CLASS_W-1:0] source_pick;
  logic [SRA_EV_W-1:0]    top_delta;
  logic [SRA_CLASS_W-1:0] top_class;

  decision_t expected_decisions[$];
  int        mismatch_count = 0;

  assign fail_count = mismatch_count;

  task automatic clear_state();
    run_interval   = SRA_RST_RUN_INTERVAL;
    idle_rounds    = SRA_RST_IDLE_ROUNDS;
    win_rounds     = SRA_RST_WIN_ROUNDS;
    min_pages      = SRA_RST_MIN_PAGES;
    for (int c = 0; c < SRA_MAX_CLASSES; c++) begin
      prev_ev[c]  = '0;
      idle_run[c] = '0;
    end
    leader_class   = '0;
    lead_count     = '0;
    next_eval_time = '0;
    round_counts   = 1'b0;
    round_open     = 1'b0;
    source_pick    = '0;
    top_delta      = '0;
    top_class      = '0;
  endtask

  // Advance the round by one class record; a closing record yields one decision.
  task automatic rebalance_step(input logic [SRA_TIME_W-1:0] now,
                                input logic [SRA_CLASS_W-1:0] cls,
                                input logic [SRA_EV_W-1:0] ev,
                                input logic [SRA_PAGES_W-1:0] pg,
                                input logic closing,
                                output bit produced,
                                output decision_t res);
    logic [SRA_CLASS_W-1:0] dest;
    logic [SRA_EV_W-1:0]    delta;
    dest     = '0;
    produced = 1'b0;
    res      = '0;

    // The first record of a round opens it and applies the time gate.
    if (!round_open) begin
      round_open  = 1'b1;
      source_pick = '0;
      top_delta   = '0;
      top_class   = '0;
      if (now >= next_eval_time) begin
        next_eval_time = now + run_interval;
        round_counts   = 1'b1;
      end else begin
        round_counts = 1'b0;
      end
    end

    if (!closing) begin
      // Only in-range classes of an evaluated round touch the history.
      if (round_counts && cls != 0 && int'(cls) < SRA_MAX_CLASSES) begin
        delta = ev - prev_ev[cls];
        if (delta == 0 && pg > min_pages) begin
          if (idle_run[cls] != SRA_CNT_MAX) idle_run[cls] = idle_run[cls] + 1'b1;
          if (source_pick == 0 && idle_run[cls] >= idle_rounds) source_pick = cls;
        end else begin
          idle_run[cls] = '0;
          if (delta > top_delta) begin
            top_delta = delta;
            top_class = cls;
          end
        end
        prev_ev[cls] = ev;
      end
    end else begin
      round_open = 1'b0;
      produced   = 1'b1;
      if (round_counts) begin
        // Consecutive wins of the same class lead to a destination.
        if (leader_class != 0 && leader_class == top_class) begin
          if (lead_count != SRA_CNT_MAX) lead_count = lead_count + 1'b1;
          if (lead_count >= win_rounds) dest = leader_class;
        end else begin
          lead_count   = SRA_CNT_W'(1);
          leader_class = top_class;
        end
        res.evaluated    = 1'b1;
        res.decided      = (source_pick != 0 && dest != 0);
        res.source_class = source_pick;
        res.dest_class   = dest;
        round_counts     = 1'b0;
      end
    end
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Sample all channels at the rising edge.
  always @(posedge clk) begin
    bit        produced;
    decision_t fresh;
    decision_t want;
    if (!rst_n) begin
      clear_state();
      expected_decisions.delete();
    end else begin
      if (cfg_we) begin
        case (sra_reg_t'(cfg_index))
          SRA_REG_RUN_INTERVAL: run_interval = cfg_data;
          SRA_REG_IDLE_ROUNDS:  idle_rounds  = cfg_data[7:0];
          SRA_REG_WIN_ROUNDS:   win_rounds   = cfg_data[7:0];
          SRA_REG_MIN_PAGES:    min_pages    = cfg_data;
          default: ;
        endcase
      end

      // Compare an accepted decision with the oldest one predicted.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_decisions.size() == 0) begin
          $error("decision item arrived with none predicted");
          mismatch_count++;
        end else begin
          want = expected_decisions.pop_front();
          check_field("evaluated", 8'(want.evaluated), 8'(out_ch.evaluated));
          check_field("decided", 8'(want.decided), 8'(out_ch.decided));
          check_field("source_class", want.source_class, out_ch.source_class);
          check_field("dest_class", want.dest_class, out_ch.dest_class);
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        rebalance_step(in_ch.now, in_ch.class_index, in_ch.evictions, in_ch.pages,
                       in_ch.last, produced, fresh);
        if (produced) expected_decisions.push_back(fresh);
      end
    end
    decisions_due = expected_decisions.size();
  end

endmodule

@@ test/tb.sv @@
// Top of the automover testbench: clock, reset, stimulus, register programming and verdict.
module tb;
  import sra_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [1:0]           cfg_index;
  logic [SRA_CFG_W-1:0] cfg_data;
  int                   fail_count;
  int                   decisions_due;

  sra_in_if  in_ch();
  sra_out_if out_ch();

  slab_rebalance_automover dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sra_decision_monitor mon (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .decisions_due (decisions_due)
  );

  // Stimulus knobs and the sender's view of time and evictions.
  int          send_idle_pct = 0;
  int          take_idle_pct = 0;
  int          stall_cycles = 0;
  logic [31:0] clock_now;
  logic [15:0] interval_q;
  logic [15:0] min_pages_q;
  logic [7:0]  hot_class;
  logic [63:0] ev_sent [SRA_MAX_CLASSES];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result channel back-pressure.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= take_idle_pct);
  end

  // End the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("slab_rebalance_automover test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one class record and hold it until it is taken.
  task automatic send_item(input logic [31:0] now, input logic [7:0] cls,
                           input logic [63:0] ev, input logic [15:0] pg,
                           input logic closing);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.now         <= now;
    in_ch.class_index <= cls;
    in_ch.evictions   <= ev;
    in_ch.pages       <= pg;
    in_ch.last        <= closing;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input sra_reg_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // Registers change only once the block has drained and settled.
  task automatic program_regs(input logic [15:0] ri, input logic [7:0] ir,
                              input logic [7:0] wr, input logic [15:0] mp);
    in_ch.valid <= 1'b0;
    while (decisions_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(SRA_REG_RUN_INTERVAL, ri);
    write_reg(SRA_REG_IDLE_ROUNDS, 16'(ir));
    write_reg(SRA_REG_WIN_ROUNDS, 16'(wr));
    write_reg(SRA_REG_MIN_PAGES, mp);
    cfg_we      <= 1'b0;
    interval_q  = ri;
    min_pages_q = mp;
    hot_class   = 8'($urandom_range(1, 8));
  endtask

  // One round over classes 1 to 8 in ascending order; a noisy round mixes in stray classes.
  task automatic send_round(input bit noisy);
    logic [7:0]  cls;
    logic [63:0] ev;
    logic [15:0] pg;
    int          pick;
    bit          opening;
    opening = 1'b1;

    // Mostly past the gate, sometimes too early, now and then a jump anywhere.
    pick = $urandom_range(0, 99);
    if (pick < 80) clock_now = clock_now + interval_q + $urandom_range(0, 3);
    else if (pick < 95) clock_now = clock_now + $urandom_range(0, interval_q);
    else clock_now = $urandom;

    for (int c = 1; c <= 8; c++) begin
      if ($urandom_range(0, 99) < ((c == hot_class) ? 90 : 50)) begin
        cls = 8'(c);
        if (noisy && $urandom_range(0, 99) < 15) cls = 8'($urandom_range(0, 255));

        // The hot class tends to lead the eviction race.
        pick = $urandom_range(0, 99);
        if (cls == hot_class && pick < 70) ev = ev_sent[cls] + 64'($urandom_range(200, 400));
        else if (pick < 40) ev = ev_sent[cls];
        else if (pick < 75) ev = ev_sent[cls] + 64'($urandom_range(1, 200));
        else if (pick < 85) ev = ev_sent[cls] + 64'($urandom_range(200, 400));
        else ev = {$urandom, $urandom};

        pick = $urandom_range(0, 99);
        if (pick < 25) pg = 16'($urandom);
        else if (pick < 35 || min_pages_q == 16'hFFFF) pg = min_pages_q;
        else pg = 16'($urandom_range(min_pages_q + 1, 65535));

        send_item(opening ? clock_now : $urandom, cls, ev, pg, 1'b0);
        ev_sent[cls] = ev;
        opening = 1'b0;
      end
    end
    send_item(opening ? clock_now : $urandom, noisy ? 8'($urandom_range(0, 255)) : 8'd9,
              {$urandom, $urandom}, 16'($urandom), 1'b1);
  endtask

  initial begin
    int c;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.now         = '0;
    in_ch.class_index = '0;
    in_ch.evictions   = '0;
    in_ch.pages       = '0;
    in_ch.last        = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = SRA_REG_RUN_INTERVAL;
    cfg_data          = '0;
    interval_q        = SRA_RST_RUN_INTERVAL;
    min_pages_q       = SRA_RST_MIN_PAGES;
    hot_class         = 8'd2;
    for (int k = 0; k < SRA_MAX_CLASSES; k++) ev_sent[k] = '0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 20;
    take_idle_pct = 68;

    // Directed rounds under the reset register values.
    // Idle class, tie on delta, pages at the minimum, closing item at full range.
    send_item(32'd0, 8'd1, 64'd0, 16'd100, 1'b0);
    send_item(32'd0, 8'd2, 64'd5, 16'd0, 1'b0);
    send_item(32'd0, 8'd3, 64'd5, 16'd7, 1'b0);
    send_item(32'd0, 8'd5, 64'd0, 16'd2, 1'b0);
    send_item('1, 8'd255, '1, '1, 1'b1);
    // Too early: the whole round is skipped.
    send_item(32'd5, 8'd2, 64'd100, 16'd9, 1'b0);
    send_item(32'd5, 8'd9, 64'd0, 16'd0, 1'b1);
    // Class zero is ignored.
    send_item(32'd10, 8'd1, 64'd0, 16'd100, 1'b0);
    send_item(32'd10, 8'd2, 64'd9, 16'd1, 1'b0);
    send_item(32'd10, 8'd0, '1, '1, 1'b0);
    send_item(32'd10, 8'd9, 64'd0, 16'd0, 1'b1);
    // Source and destination both reached.
    send_item(32'd20, 8'd1, 64'd0, 16'd100, 1'b0);
    send_item(32'd20, 8'd2, 64'd20, 16'd1, 1'b0);
    send_item(32'd20, 8'd9, 64'd0, 16'd0, 1'b1);
    // A round of only the closing item has no winner.
    send_item(32'd30, 8'd9, 64'd0, 16'd0, 1'b1);
    // Time wraps; repeated class with a wrapped delta, then descending order.
    send_item(32'hFFFF_FFFA, 8'd4, '1, 16'd3, 1'b0);
    send_item(32'd0, 8'd4, 64'd0, 16'd3, 1'b0);
    send_item(32'd0, 8'd3, 64'd6, 16'd3, 1'b0);
    send_item(32'd0, 8'd9, 64'd0, 16'd0, 1'b1);
    send_item(32'd3, 8'd3, 64'd7, 16'd3, 1'b0);
    send_item(32'd3, 8'd9, 64'd0, 16'd0, 1'b1);
    send_item(32'd4, 8'd9, 64'd0, 16'd0, 1'b1);
    clock_now = 32'd4;

    // Small thresholds so decisions come often.
    program_regs(16'($urandom_range(1, 30)), 8'($urandom_range(1, 3)),
                 8'($urandom_range(1, 3)), 16'($urandom_range(0, 4)));
    repeat (80) send_round($urandom_range(0, 99) < 20);

    // Longest interval, lowest thresholds.
    send_idle_pct = 68;
    take_idle_pct = 20;
    program_regs(16'hFFFF, 8'd1, 8'd1, 16'd0);
    repeat (60) send_round($urandom_range(0, 99) < 20);

    // Highest thresholds: class 1 stays idle and class 2 keeps winning past saturation.
    program_regs(16'd0, 8'd255, 8'd255, 16'd0);
    repeat (270) begin
      clock_now = clock_now + $urandom_range(0, 5);
      send_item(clock_now, 8'd1, ev_sent[1], 16'($urandom_range(1, 65535)), 1'b0);
      ev_sent[2] = ev_sent[2] + 64'($urandom_range(1000, 5000));
      send_item($urandom, 8'd2, ev_sent[2], 16'($urandom), 1'b0);
      if ($urandom_range(0, 99) < 20) begin
        c = $urandom_range(3, 8);
        ev_sent[c] = ev_sent[c] + 64'($urandom_range(0, 500));
        send_item($urandom, 8'(c), ev_sent[c], 16'($urandom), 1'b0);
      end
      send_item($urandom, 8'd9, {$urandom, $urandom}, 16'($urandom), 1'b1);
    end

    // No class can hold more than the page minimum.
    send_idle_pct = 0;
    take_idle_pct = 0;
    program_regs(16'($urandom_range(0, 100)), 8'($urandom_range(1, 8)),
                 8'($urandom_range(1, 8)), 16'hFFFF);
    repeat (25) send_round($urandom_range(0, 99) < 20);

    program_regs(16'($urandom_range(1, 40)), 8'($urandom_range(1, 4)),
                 8'($urandom_range(1, 4)), 16'($urandom_range(0, 8)));
    repeat (20) send_round($urandom_range(0, 99) < 20);

    // Drain and let the pipeline settle before the verdict.
    in_ch.valid <= 1'b0;
    while (decisions_due != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("slab_rebalance_automover test passed");
    end else begin
      $display("slab_rebalance_automover test failed");
    end
    $finish;
  end

endmodule
